@@ sv/pi_temperature_controller_macros.svh @@
// Assertion macros shared by the temperature controller RTL.
// Included by the module that carries concurrent checks; expects clk and rst_n in scope.
`ifndef PI_TEMPERATURE_CONTROLLER_MACROS_SVH
`define PI_TEMPERATURE_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
`define PITC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pitc check failed");
`define PITC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pitc check failed");
`else
`define PITC_ASSERT_IMP(lbl, ante, cons)
`define PITC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/pitc_pkg.sv @@
// Shared types, constants and inter-module structs of the temperature controller.
// No dependencies; imported by every module of the block.
`default_nettype none
package pitc_pkg;

  localparam int WIN_N = 9;
  localparam int POS_W = (WIN_N > 1) ? $clog2(WIN_N) : 1;
  localparam int SUM_W = 17 + $clog2(WIN_N);

  typedef logic signed [15:0]    temp_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [SUM_W-1:0]      mag_t;
  typedef logic [SUM_W:0]        recip_t;
  typedef logic [2*SUM_W:0]      qprod_t;

  // floor(2^SUM_W / WIN_N): estimate is exact or one low, fixed by one compare
  localparam recip_t DIV_RECIP = recip_t'((longint'(1) << SUM_W) / WIN_N);

  localparam logic [19:0] TEMP_SCALE  = 20'd689485;
  localparam logic [31:0] TEMP_ROUND  = 32'd32768;
  localparam logic signed [16:0] TEMP_OFFSET = 17'sd11336;

  localparam logic signed [34:0] INTEG_LIMIT = 35'sd419430400;
  localparam logic [17:0] CONTROL_MAX = 18'd256000;
  localparam int DUTY_K = 26;
  localparam logic [8:0] DUTY_RECIP = 9'((longint'(1) << DUTY_K) / 256000);

  typedef enum logic [7:0] {
    CFG_SETPOINT      = 8'd0,
    CFG_PROP_GAIN     = 8'd1,
    CFG_INTEG_GAIN    = 8'd2,
    CFG_SAMPLE_PERIOD = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic  done;
    temp_t mean;
  } win_res_t;

  typedef struct packed {
    logic        start;
    temp_t       mean;
    temp_t       setpoint;
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] ts;
  } pi_req_t;

  typedef struct packed {
    logic        done;
    logic [7:0]  duty;
    logic [17:0] ctrl;
  } pi_res_t;

endpackage
`default_nettype wire

@@ sv/pitc_win.sv @@
// Sample window: sensor code conversion, window memory with running sum, mean.
// Depends on pitc_pkg.
`default_nettype none
module pitc_win import pitc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [11:0] code,
  output win_res_t         res
);

  typedef enum logic [2:0] {W_IDLE, W_CONV, W_SUM, W_ABS, W_DIV, W_FIX} wstate_t;

  wstate_t          state_r;
  pos_t             pos_r;
  logic [WIN_N-1:0] valid_r;
  sum_t             sum_r;
  logic             done_r;

  logic [31:0] prod_r;
  temp_t       temp_r;
  temp_t       old_r;
  mag_t        mag_r;
  logic        neg_r;
  qprod_t      qprod_r;
  temp_t       mean_r;

  temp_t mem_r [WIN_N];
  temp_t rd_r;
  logic  mem_we;

  logic [31:0]       rnd_sum;
  logic signed [16:0] conv;
  mag_t              q_est;
  mag_t              rem;
  mag_t              q_fix;

  assign mem_we = (state_r == W_SUM);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[pos_r] <= temp_r;
    end
    rd_r <= mem_r[pos_r];
  end

  always_comb begin
    rnd_sum = prod_r + TEMP_ROUND;
    conv    = $signed({1'b0, rnd_sum[31:16]}) - TEMP_OFFSET;
    q_est   = mag_t'(qprod_r >> SUM_W);
    rem     = mag_r - mag_t'(q_est * WIN_N);
    q_fix   = (rem >= mag_t'(WIN_N)) ? q_est + mag_t'(1) : q_est;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
      pos_r   <= '0;
      valid_r <= '0;
      sum_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        W_IDLE: begin
          if (start) begin
            state_r <= W_CONV;
          end
        end
        W_CONV: state_r <= W_SUM;
        W_SUM: begin
          // replace the oldest sample in the running sum
          sum_r          <= sum_r + sum_t'(temp_r) - sum_t'(old_r);
          valid_r[pos_r] <= 1'b1;
          pos_r          <= (pos_r == pos_t'(WIN_N - 1)) ? '0 : pos_r + pos_t'(1);
          state_r        <= W_ABS;
        end
        W_ABS: state_r <= W_DIV;
        W_DIV: state_r <= W_FIX;
        W_FIX: begin
          done_r  <= 1'b1;
          state_r <= W_IDLE;
        end
        default: state_r <= W_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == W_IDLE && start) begin
      prod_r <= 32'(code) * 32'(TEMP_SCALE);
    end
    if (state_r == W_CONV) begin
      temp_r <= temp_t'(conv);
      old_r  <= valid_r[pos_r] ? rd_r : '0;
    end
    if (state_r == W_ABS) begin
      neg_r <= sum_r[SUM_W-1];
      mag_r <= sum_r[SUM_W-1] ? mag_t'(-sum_r) : mag_t'(sum_r);
    end
    if (state_r == W_DIV) begin
      qprod_r <= qprod_t'(mag_r) * qprod_t'(DIV_RECIP);
    end
    if (state_r == W_FIX) begin
      // truncate toward zero: divide the magnitude, restore the sign
      mean_r <= neg_r ? temp_t'(-q_fix) : temp_t'(q_fix);
    end
  end

  assign res.done = done_r;
  assign res.mean = mean_r;

endmodule
`default_nettype wire

@@ sv/pitc_pi.sv @@
// Velocity-form PI step with clamped integral and control level, and duty scaling.
// Depends on pitc_pkg.
`default_nettype none
module pitc_pi import pitc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  pi_req_t   req,
  output pi_res_t   res
);

  typedef logic signed [16:0] err_t;
  typedef logic signed [17:0] delta_t;
  typedef logic signed [33:0] ip_t;
  typedef logic signed [34:0] isum_t;
  typedef logic signed [29:0] integ_t;
  typedef logic signed [34:0] pp_t;
  typedef logic signed [46:0] kp_t;
  typedef logic signed [59:0] inc_t;
  typedef logic signed [28:0] rnd_t;
  typedef logic signed [29:0] acc_t;
  typedef logic [25:0]        x_t;
  typedef logic [34:0]        dp_t;

  typedef enum logic [3:0] {
    P_IDLE, P_IMUL, P_INT, P_PMUL, P_KMUL, P_ADD, P_RND, P_ACC, P_DX, P_DMUL, P_DFIX
  } pstate_t;

  pstate_t     state_r;
  integ_t      integ_r;
  err_t        prev_r;
  logic [17:0] ctrl_r;
  logic        done_r;

  err_t       err_r;
  delta_t     delta_r;
  ip_t        ip_r;
  pp_t        pprod_r;
  kp_t        kprod_r;
  inc_t       inc_r;
  rnd_t       rnd_r;
  x_t         x_r;
  dp_t        dprod_r;
  logic [7:0] duty_r;

  isum_t      isum;
  integ_t     integ_nxt;
  inc_t       bias;
  inc_t       rsum;
  acc_t       asum;
  logic [17:0] ctrl_nxt;
  logic [7:0] q_est;
  x_t         rem;

  always_comb begin
    isum = isum_t'(integ_r) + isum_t'(ip_r);
    if (isum > INTEG_LIMIT) begin
      integ_nxt = integ_t'(INTEG_LIMIT);
    end else if (isum < -INTEG_LIMIT) begin
      integ_nxt = integ_t'(-INTEG_LIMIT);
    end else begin
      integ_nxt = integ_t'(isum);
    end

    // half away from zero: negative values take one less of the half bias
    bias = inc_r[59] ? inc_t'(32'h7FFF_FFFF) : inc_t'(32'h8000_0000);
    rsum = inc_r + bias;

    asum = acc_t'(ctrl_r) + acc_t'(rnd_r);
    if (asum < 0) begin
      ctrl_nxt = '0;
    end else if (asum > acc_t'(CONTROL_MAX)) begin
      ctrl_nxt = CONTROL_MAX;
    end else begin
      ctrl_nxt = asum[17:0];
    end

    q_est = 8'(dprod_r >> DUTY_K);
    rem   = x_r - x_t'(q_est) * x_t'(CONTROL_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      integ_r <= '0;
      prev_r  <= '0;
      ctrl_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        P_IDLE: begin
          if (req.start) begin
            state_r <= P_IMUL;
          end
        end
        P_IMUL: state_r <= P_INT;
        P_INT: begin
          integ_r <= integ_nxt;
          prev_r  <= err_r;
          state_r <= P_PMUL;
        end
        P_PMUL: state_r <= P_KMUL;
        P_KMUL: state_r <= P_ADD;
        P_ADD:  state_r <= P_RND;
        P_RND:  state_r <= P_ACC;
        P_ACC: begin
          ctrl_r  <= ctrl_nxt;
          state_r <= P_DX;
        end
        P_DX:   state_r <= P_DMUL;
        P_DMUL: state_r <= P_DFIX;
        P_DFIX: begin
          done_r  <= 1'b1;
          state_r <= P_IDLE;
        end
        default: state_r <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == P_IDLE && req.start) begin
      err_r <= err_t'(req.setpoint) - err_t'(req.mean);
    end
    if (state_r == P_IMUL) begin
      ip_r    <= ip_t'(err_r) * ip_t'($signed({1'b0, req.ts}));
      delta_r <= delta_t'(err_r) - delta_t'(prev_r);
    end
    if (state_r == P_PMUL) begin
      pprod_r <= pp_t'($signed({1'b0, req.kp})) * pp_t'(delta_r);
    end
    if (state_r == P_KMUL) begin
      kprod_r <= kp_t'($signed({1'b0, req.ki})) * kp_t'(integ_r);
    end
    if (state_r == P_ADD) begin
      inc_r <= (inc_t'(pprod_r) <<< 24) + inc_t'(kprod_r);
    end
    if (state_r == P_RND) begin
      rnd_r <= rnd_t'(rsum >>> 32);
    end
    if (state_r == P_DX) begin
      x_r <= {ctrl_r, 8'd0} - x_t'(ctrl_r);
    end
    if (state_r == P_DMUL) begin
      dprod_r <= dp_t'(x_r) * dp_t'(DUTY_RECIP);
    end
    if (state_r == P_DFIX) begin
      duty_r <= (rem >= x_t'(CONTROL_MAX)) ? q_est + 8'd1 : q_est;
    end
  end

  assign res.done = done_r;
  assign res.duty = duty_r;
  assign res.ctrl = ctrl_r;

endmodule
`default_nettype wire

@@ sv/pi_temperature_controller.sv @@
// Heater temperature controller: nine-sample mean of the sensor, PI regulation
// in automatic mode, hand stepping of the duty in manual mode.
//
// Input channel (in_*): one transfer per sample tick carries the 12-bit sensor
// code and the mode and step buttons. Result channel (out_*): one transfer per
// input item with duty, mode flag, mean temperature and control level.
// Configuration channel (cfg_*): setpoint and gains, always ready; write it
// only while no item is in flight. Indexes beyond the register list are dropped.
// The result passes through the window memory read-modify-write and, in
// automatic mode, the chain of PI multiplies, each registered before the next.
// in_tready rises again in the cycle the result is registered, so the next
// item is taken only once the result is registered.
// A stalled receiver holds the result in the output register; the next item is
// still accepted and waits at the end of its processing for the register.
// Reset (rst_n low, synchronous) clears the window, the PI state, the duty and
// the mode, and loads the default setpoint and gains.
`default_nettype none
`include "pi_temperature_controller_macros.svh"
module pi_temperature_controller import pitc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] sensor_code, [12] mode_button, [13] step_button
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [47:0] out_tdata,  // [7:0] duty, [8] manual_active,
                                       // [24:9] filtered_temp, [42:25] control_level
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  typedef enum logic [1:0] {T_IDLE, T_WIN, T_PI, T_OUT} tstate_t;

  tstate_t     state_r;
  logic        manual_r;
  logic [7:0]  duty_r;
  logic        out_tvalid_r;
  temp_t       setpoint_r;
  logic [15:0] kp_r;
  logic [15:0] ki_r;
  logic [15:0] ts_r;

  logic        mode_r;
  logic        step_r;
  logic [47:0] out_tdata_r;

  win_res_t win_res;
  pi_req_t  pi_req;
  pi_res_t  pi_res;

  logic       accept;
  logic       manual_nxt;
  logic [7:0] duty_base;
  logic [7:0] duty_inc;
  logic       out_load;

  assign in_tready = (state_r == T_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign manual_nxt = manual_r ^ mode_r;
  assign duty_base  = mode_r ? 8'd0 : duty_r;
  assign duty_inc   = (duty_base + 8'd1 == 8'hFF) ? 8'd0 : duty_base + 8'd1;
  assign out_load   = (state_r == T_OUT) && (!out_tvalid_r || out_tready);

  assign pi_req.start    = (state_r == T_WIN) && win_res.done && !manual_nxt;
  assign pi_req.mean     = win_res.mean;
  assign pi_req.setpoint = setpoint_r;
  assign pi_req.kp       = kp_r;
  assign pi_req.ki       = ki_r;
  assign pi_req.ts       = ts_r;

  pitc_win u_win (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .code  (in_tdata[11:0]),
    .res   (win_res)
  );

  pitc_pi u_pi (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pi_req),
    .res   (pi_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r <= 16'sd12800;
      kp_r       <= 16'd6400;
      ki_r       <= 16'd655;
      ts_r       <= 16'd6554;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SETPOINT:      setpoint_r <= temp_t'(cfg_data);
        CFG_PROP_GAIN:     kp_r       <= cfg_data;
        CFG_INTEG_GAIN:    ki_r       <= cfg_data;
        CFG_SAMPLE_PERIOD: ts_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      manual_r     <= 1'b0;
      duty_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (accept) begin
            state_r <= T_WIN;
          end
        end
        T_WIN: begin
          if (win_res.done) begin
            // mode toggle first, then either PI or the step button
            manual_r <= manual_nxt;
            if (!manual_nxt) begin
              duty_r  <= duty_base;
              state_r <= T_PI;
            end else begin
              duty_r  <= step_r ? duty_inc : duty_base;
              state_r <= T_OUT;
            end
          end
        end
        T_PI: begin
          if (pi_res.done) begin
            duty_r  <= pi_res.duty;
            state_r <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_load) begin
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_tdata[12];
      step_r <= in_tdata[13];
    end
    if (out_load) begin
      out_tdata_r <= {5'd0, pi_res.ctrl, win_res.mean, manual_r, duty_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `PITC_ASSERT_NXT(a_accept_busy, in_tvalid && in_tready, !in_tready)
  `PITC_ASSERT_IMP(a_manual_duty, out_tvalid && out_tdata[8], out_tdata[7:0] != 8'hFF)
  `PITC_ASSERT_IMP(a_ctrl_range, out_tvalid, out_tdata[42:25] <= CONTROL_MAX)
  `PITC_ASSERT_IMP(a_pi_done_state, pi_res.done, state_r == T_PI)

endmodule
`default_nettype wire

@@ tb/tb_pi_temperature_controller.sv @@
// Self-checking bench for pi_temperature_controller: a directed table, a manual duty
// wrap run, then random sample streams over several register settings.
// Depends on pitc_pkg and the controller RTL; results are checked by a built-in predictor.
`default_nettype none
module tb_pi_temperature_controller;
  import pitc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SENSOR_GAIN   = 689485;
  localparam longint SENSOR_OFFSET = 11336;
  localparam longint INTEG_CLAMP   = 419430400;
  localparam longint LEVEL_MAX     = 256000;
  localparam logic [7:0] CFG_IDX_SPARE = 8'd4;
  localparam logic [7:0] CFG_IDX_TOP   = 8'hFF;

  typedef struct packed {
    logic [7:0]         duty;
    logic               manual;
    logic signed [15:0] mean;
    logic [17:0]        level;
  } reading_t;

  typedef struct packed {
    logic [11:0] code;
    logic        mode;
    logic        step;
    logic        typed;
    reading_t    want;
  } stim_row_t;

  typedef struct {
    logic signed [15:0] sp;
    logic [15:0]        kp;
    logic [15:0]        ki;
    logic [15:0]        ts;
    int                 items;
    bit                 quiet;
    bit                 shuffle;
  } gain_set_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [11:0] sensor_code, [12] mode_button, [13] step_button
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [7:0] duty, [8] manual_active,
                           // [24:9] filtered_temp, [42:25] control_level
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;

  pi_temperature_controller DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Controller shadow: registers and state
  logic signed [15:0] sp_reg;
  logic [15:0]        kp_reg;
  logic [15:0]        ki_reg;
  logic [15:0]        ts_reg;
  longint             window_temps [WIN_N];
  int                 window_slot;
  longint             integ_acc;
  longint             prev_err;
  longint             level_acc;
  int                 duty_lvl;
  bit                 manual_on;

  reading_t pending_readings [$];
  int       results_seen;
  int       mismatches;
  bit       no_idle;
  int       hold_left;
  bit       long_hold_done;

  // Directed rows; the first three carry hand-computed results after reset
  stim_row_t directed_rows [22] = '{
    '{12'd0,    1'b0, 1'b0, 1'b1, '{8'd255, 1'b0, -16'sd1259, 18'd256000}},
    '{12'd0,    1'b1, 1'b0, 1'b1, '{8'd0,   1'b1, -16'sd2519, 18'd256000}},
    '{12'd0,    1'b0, 1'b1, 1'b1, '{8'd1,   1'b1, -16'sd3778, 18'd256000}},
    '{12'd4095, 1'b0, 1'b1, 1'b0, '0},
    '{12'd4095, 1'b0, 1'b0, 1'b0, '0},
    '{12'hAAA,  1'b0, 1'b1, 1'b0, '0},
    '{12'h555,  1'b0, 1'b0, 1'b0, '0},
    '{12'd4095, 1'b1, 1'b1, 1'b0, '0},
    '{12'd4095, 1'b0, 1'b0, 1'b0, '0},
    '{12'd4095, 1'b0, 1'b0, 1'b0, '0},
    '{12'h800,  1'b0, 1'b1, 1'b0, '0},
    '{12'h7FF,  1'b0, 1'b0, 1'b0, '0},
    '{12'd4095, 1'b1, 1'b1, 1'b0, '0},
    '{12'd0,    1'b0, 1'b1, 1'b0, '0},
    '{12'd0,    1'b1, 1'b0, 1'b0, '0},
    '{12'd2294, 1'b0, 1'b0, 1'b0, '0},
    '{12'd2294, 1'b0, 1'b1, 1'b0, '0},
    '{12'd2300, 1'b1, 1'b0, 1'b0, '0},
    '{12'd2300, 1'b1, 1'b0, 1'b0, '0},
    '{12'd0,    1'b0, 1'b0, 1'b0, '0},
    '{12'd4095, 1'b0, 1'b0, 1'b0, '0},
    '{12'd2294, 1'b0, 1'b0, 1'b0, '0}
  };

  gain_set_t gain_sets [8] = '{
    '{16'sd6400,   16'd6400,  16'd655,   16'd6554,  80, 1'b0, 1'b0},
    '{-16'sd11336, 16'd0,     16'd0,     16'd0,     70, 1'b0, 1'b0},
    '{16'sd31830,  16'd65535, 16'd65535, 16'd65535, 70, 1'b1, 1'b0},
    '{-16'sd32768, 16'd65535, 16'd0,     16'd1,     70, 1'b0, 1'b0},
    '{16'sd32767,  16'd1,     16'd65535, 16'd65535, 70, 1'b0, 1'b0},
    '{16'sd12800,  16'd256,   16'd6554,  16'd0,     80, 1'b0, 1'b0},
    '{16'sd0,      16'd0,     16'd0,     16'd0,     60, 1'b0, 1'b1},
    '{16'sd0,      16'd0,     16'd0,     16'd0,     60, 1'b0, 1'b1}
  };

  function automatic void reset_shadow();
    sp_reg      = 16'sd12800;
    kp_reg      = 16'd6400;
    ki_reg      = 16'd655;
    ts_reg      = 16'd6554;
    for (int k = 0; k < WIN_N; k++) window_temps[k] = 0;
    window_slot = 0;
    integ_acc   = 0;
    prev_err    = 0;
    level_acc   = 0;
    duty_lvl    = 0;
    manual_on   = 1'b0;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Q.40 to Q.8, ties away from zero
  function automatic longint round_to_q8(longint v);
    if (v >= 0) return (v + 64'sd2147483648) >>> 32;
    return -((-v + 64'sd2147483648) >>> 32);
  endfunction

  function automatic reading_t advance_controller(logic [11:0] code, bit mode, bit step);
    longint   celsius;
    longint   total;
    longint   mean_q;
    longint   err;
    longint   inc;
    reading_t r;
    celsius = ((longint'(code) * SENSOR_GAIN + 32768) >>> 16) - SENSOR_OFFSET;
    window_temps[window_slot] = celsius;
    window_slot = (window_slot + 1) % WIN_N;
    total = 0;
    for (int k = 0; k < WIN_N; k++) total += window_temps[k];
    mean_q = total / WIN_N;
    if (mode) begin
      duty_lvl  = 0;
      manual_on = !manual_on;
    end
    if (!manual_on) begin
      err       = longint'(sp_reg) - mean_q;
      integ_acc = clamp(integ_acc + err * longint'(ts_reg), -INTEG_CLAMP, INTEG_CLAMP);
      inc       = longint'(kp_reg) * (err - prev_err) * 64'sd16777216
                + longint'(ki_reg) * integ_acc;
      level_acc = clamp(level_acc + round_to_q8(inc), 0, LEVEL_MAX);
      prev_err  = err;
      duty_lvl  = int'(level_acc * 255 / LEVEL_MAX);
    end else if (step) begin
      duty_lvl = (duty_lvl + 1) % 256;
      if (duty_lvl == 255) duty_lvl = 0;
    end
    r.duty   = duty_lvl[7:0];
    r.manual = manual_on;
    r.mean   = mean_q[15:0];
    r.level  = level_acc[17:0];
    return r;
  endfunction

  function automatic int code_for_setpoint(logic signed [15:0] sp);
    longint c;
    c = ((longint'(sp) + SENSOR_OFFSET) * 65536) / SENSOR_GAIN;
    return int'(clamp(c, 0, 4095));
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic offer_sample(logic [11:0] code, bit mode, bit step, bit typed,
                              reading_t typed_want);
    reading_t predicted;
    while (!no_idle && $urandom_range(0, 99) < 7) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {2'b00, step, mode, code};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = advance_controller(code, mode, step);
    pending_readings.push_back(typed ? typed_want : predicted);
    @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write of a group
  task automatic write_register(logic [7:0] idx, logic [15:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SETPOINT:      sp_reg = value;
      CFG_PROP_GAIN:     kp_reg = value;
      CFG_INTEG_GAIN:    ki_reg = value;
      CFG_SAMPLE_PERIOD: ts_reg = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Wait out every pending result plus the pipeline depth; ends on a falling edge
  task automatic wait_drained();
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_samples(int count, logic signed [15:0] sp);
    int          center;
    int          c;
    logic [11:0] code;
    center = code_for_setpoint(sp);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        code = 12'($urandom_range(0, 4095));
      end else begin
        c    = center + int'($urandom_range(0, 128)) - 64;
        code = 12'(clamp(c, 0, 4095));
      end
      offer_sample(code, $urandom_range(0, 99) < 4, $urandom_range(0, 99) < 35, 1'b0, '0);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: random backpressure plus one long hold-off mid-run
  initial begin
    out_tready     = 1'b0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (results_seen >= 150 && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left      = 80;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= rst_n && (no_idle || $urandom_range(0, 99) >= 7);
      end
    end
  end

  always @(posedge clk) begin : check_results
    reading_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected transfer, data", longint'(out_tdata), 0);
      end else begin
        want = pending_readings.pop_front();
        if (out_tdata[7:0] !== want.duty)
          report_mismatch("duty", out_tdata[7:0], want.duty);
        if (out_tdata[8] !== want.manual)
          report_mismatch("manual_active", out_tdata[8], want.manual);
        if (out_tdata[24:9] !== want.mean)
          report_mismatch("filtered_temp", longint'($signed(out_tdata[24:9])),
                          longint'(want.mean));
        if (out_tdata[42:25] !== want.level)
          report_mismatch("control_level", out_tdata[42:25], want.level);
      end
      results_seen++;
    end
  end

  initial begin
    gain_set_t g;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    no_idle      = 1'b0;
    results_seen = 0;
    mismatches   = 0;
    reset_shadow();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      offer_sample(directed_rows[i].code, directed_rows[i].mode, directed_rows[i].step,
                   directed_rows[i].typed, directed_rows[i].want);

    // Manual run long enough to carry the duty through its wrap back to zero
    if (!manual_on) offer_sample(12'd2294, 1'b1, 1'b0, 1'b0, '0);
    for (int n = 0; n < 256; n++)
      offer_sample(12'($urandom_range(0, 4095)), 1'b0, 1'b1, 1'b0, '0);
    offer_sample(12'd2294, 1'b1, 1'b0, 1'b0, '0);
    in_tvalid <= 1'b0;

    foreach (gain_sets[i]) begin
      g = gain_sets[i];
      if (g.shuffle) begin
        g.sp = 16'(int'($urandom_range(0, 43166)) - 11336);
        g.kp = 16'($urandom_range(0, 4000));
        g.ki = 16'($urandom_range(0, 65535));
        g.ts = 16'($urandom_range(0, 65535));
      end
      wait_drained();
      if (i == 0) begin
        write_register(CFG_IDX_SPARE, 16'hFFFF);
        write_register(CFG_IDX_TOP, 16'h0000);
      end
      write_register(CFG_SETPOINT, g.sp);
      write_register(CFG_PROP_GAIN, g.kp);
      write_register(CFG_INTEG_GAIN, g.ki);
      write_register(CFG_SAMPLE_PERIOD, g.ts);
      cfg_valid <= 1'b0;
      no_idle = g.quiet;
      random_samples(g.items, g.sp);
      no_idle = 1'b0;
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
